### rtl/iol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_pkg: shared types and codes for the indexed ordered list
// Command and status codes, the per-cell operation and the scan-wave control.
// ----------------------------------------------------------------------------
package iol_pkg;

	// Request command codes
	localparam logic [1:0] CMD_INSERT       = 2'd0;
	localparam logic [1:0] CMD_REMOVE       = 2'd1;
	localparam logic [1:0] CMD_REMOVE_MATCH = 2'd2;
	localparam logic [1:0] CMD_READ         = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// Operation broadcast to every cell
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     by_value;   // scan matches on value, not on position
	} cell_ctrl_t;

	// Scan wave control handed from cell to cell
	typedef struct packed {
		logic vld;
		logic found;
	} scan_t;

endpackage

### rtl/iol_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_cell: one list slot of the indexed ordered list
// Holds one entry, shifts it to or from its neighbors, and passes the scan
// wave one slot further each cycle.
// ----------------------------------------------------------------------------
module iol_cell import iol_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int CW         = 5,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctrl_t            ctrl,
	input  logic [CW-1:0]         pos,
	input  logic [CW-1:0]         cnt,
	input  logic [DATA_WIDTH-1:0] val,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  scan_t                 scan_in,
	input  logic [DATA_WIDTH-1:0] scan_data_in,
	output scan_t                 scan_out,
	output logic [DATA_WIDTH-1:0] scan_data_out,
	output logic [DATA_WIDTH-1:0] data
);

	localparam logic [CW-1:0] MY_POS = CW'(IDX);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] scan_data_q;
	scan_t                 scan_q;
	logic                  mark_q;
	logic                  hit;

	// This slot is the first one that satisfies the scan
	always_comb begin
		if (ctrl.by_value)
			hit = (data_q == val) && (MY_POS < cnt);
		else
			hit = (MY_POS == pos);
		hit = hit && scan_in.vld && !scan_in.found;
	end

	// Entry storage: open a gap on insert, close it on remove
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				if (MY_POS == pos)
					data_q <= val;
				else if (MY_POS > pos)
					data_q <= left_data;
			end
			CELL_REMOVE: begin
				if (mark_q)
					data_q <= right_data;
			end
			default: ;
		endcase
	end

	// Scan wave; mark is set from the hit slot onward
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			mark_q <= 1'b0;
		end else if (scan_in.vld) begin
			scan_q.vld   <= 1'b1;
			scan_q.found <= scan_in.found | hit;
			mark_q       <= scan_in.found | hit;
		end else begin
			scan_q.vld <= 1'b0;
		end
	end

	// Scan payload: picks up this entry on a hit
	always_ff @(posedge clk) begin
		if (scan_in.vld)
			scan_data_q <= hit ? data_q : scan_data_in;
	end

	assign scan_out      = scan_q;
	assign scan_data_out = scan_data_q;
	assign data          = data_q;

endmodule

### rtl/indexed_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_ordered_list: bounded ordered list with insert, remove and read
// A row of CAPACITY cells holds the list in order; the top level tracks the
// count, checks ranges and sequences the scan wave.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and each request
// gives exactly one result, shown for one cycle with done high; the receiver
// cannot stall it. Insert, and any request rejected by a range or full check,
// answers in the cycle after acceptance and leaves busy low, so these can be
// issued every cycle. Remove at position, remove first match and read keep
// busy high from acceptance until done: the search walks the cell chain as a
// wave that advances one cell per cycle, and the removal shift happens in
// the cycle the wave leaves the last cell. Only the low DATA_WIDTH bits of
// item_value are stored and matched.
// ----------------------------------------------------------------------------
module indexed_ordered_list import iol_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [4:0]  position,
	input  logic [31:0] item_value,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] value_out,
	output logic [4:0]  count_out,
	output logic        is_empty
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;
	localparam int XW   = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	typedef enum logic {S_IDLE, S_SCAN} state_t;

	state_t                state_q;
	logic [1:0]            cmd_q;
	logic [CW-1:0]         pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [CW-1:0]         count_q;
	logic                  launch_q;
	logic                  done_q;
	logic [1:0]            status_q;
	logic [31:0]           value_q;

	logic                  accept;
	logic [CMPW-1:0]       pos_x;
	logic [CMPW-1:0]       cnt_x;
	logic [XW-1:0]         val_x;
	logic [XW-1:0]         got_x;
	logic [DATA_WIDTH-1:0] val_dw;
	logic                  ins_range;
	logic                  is_full;
	logic                  idx_range;
	cell_ctrl_t            ctrl;
	logic [CW-1:0]         pos_b;
	logic [DATA_WIDTH-1:0] val_b;
	scan_t                 exit_scan;

	scan_t                 scan_w  [CAPACITY+1];
	logic [DATA_WIDTH-1:0] sdata_w [CAPACITY+1];
	logic [DATA_WIDTH-1:0] data_w  [CAPACITY];

	// Request checks
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign pos_x     = CMPW'(position);
	assign cnt_x     = CMPW'(count_q);
	assign val_x     = XW'(item_value);
	assign val_dw    = val_x[DATA_WIDTH-1:0];
	assign ins_range = pos_x > cnt_x;
	assign is_full   = (count_q == CAP_CNT);
	assign idx_range = pos_x >= cnt_x;
	assign exit_scan = scan_w[CAPACITY];
	assign got_x     = XW'(sdata_w[CAPACITY]);

	// Broadcast to the cells
	always_comb begin
		pos_b         = busy ? pos_q : pos_x[CW-1:0];
		val_b         = busy ? val_q : val_dw;
		ctrl.op       = CELL_HOLD;
		ctrl.by_value = (cmd_q == CMD_REMOVE_MATCH);
		if (accept && command == CMD_INSERT && !ins_range && !is_full)
			ctrl.op = CELL_INSERT;
		else if (state_q == S_SCAN && exit_scan.vld && exit_scan.found
				&& cmd_q != CMD_READ)
			ctrl.op = CELL_REMOVE;
	end

	// Scan wave enters at the head of the chain
	assign scan_w[0].vld   = launch_q;
	assign scan_w[0].found = 1'b0;
	assign sdata_w[0]      = '0;

	// Cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_head
			assign left_d = val_b;
		end else begin : g_left
			assign left_d = data_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_d = data_w[i];
		end else begin : g_right
			assign right_d = data_w[i+1];
		end

		iol_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CW         (CW),
			.IDX        (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.pos           (pos_b),
			.cnt           (count_q),
			.val           (val_b),
			.left_data     (left_d),
			.right_data    (right_d),
			.scan_in       (scan_w[i]),
			.scan_data_in  (sdata_w[i]),
			.scan_out      (scan_w[i+1]),
			.scan_data_out (sdata_w[i+1]),
			.data          (data_w[i])
		);
	end

	// Sequencer, count and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= CMD_INSERT;
			pos_q    <= '0;
			val_q    <= '0;
			count_q  <= '0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			value_q  <= '0;
		end else begin
			done_q   <= 1'b0;
			launch_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= command;
						pos_q   <= pos_x[CW-1:0];
						val_q   <= val_dw;
						value_q <= '0;
						unique case (command) inside
							CMD_INSERT: begin
								done_q <= 1'b1;
								if (ins_range) begin
									status_q <= ST_RANGE;
								end else if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									count_q  <= count_q + CW'(1);
								end
							end
							CMD_REMOVE, CMD_READ: begin
								if (idx_range) begin
									done_q   <= 1'b1;
									status_q <= ST_RANGE;
								end else begin
									state_q  <= S_SCAN;
									launch_q <= 1'b1;
								end
							end
							CMD_REMOVE_MATCH: begin
								state_q  <= S_SCAN;
								launch_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (exit_scan.vld) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						if (exit_scan.found) begin
							status_q <= ST_OK;
							value_q  <= got_x[31:0];
							if (cmd_q != CMD_READ)
								count_q <= count_q - CW'(1);
						end else begin
							status_q <= ST_NOTFOUND;
							value_q  <= '0;
						end
					end
				end
			endcase
		end
	end

	// Result ports
	assign done      = done_q;
	assign status    = status_q;
	assign value_out = value_q;
	assign count_out = cnt_x[4:0];
	assign is_empty  = (count_q == '0);

	// Count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("count above capacity");

	// Count changes only together with a result
	a_count_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> done_q)
		else $error("count changed without a result");

	// A full status comes only from a full list
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_FULL) |-> (count_q == CAP_CNT))
		else $error("full status with room left");

	// Errors return a zero word
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_OK) |-> (value_q == '0))
		else $error("nonzero word on error");

	// The wave leaves the chain only during a scan
	a_wave_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		exit_scan.vld |-> (state_q == S_SCAN))
		else $error("scan wave outside a scan");

endmodule

### tb/list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_checker: request/result scoreboard for the indexed ordered list
// Watches the request and result channels. Each accepted request is applied
// to a local copy of the list, and the outcome is queued. Each done strobe is
// compared field by field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module list_checker import iol_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  command,
	input  logic [4:0]  position,
	input  logic [31:0] item_value,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [31:0] value_out,
	input  logic [4:0]  count_out,
	input  logic        is_empty,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
		logic [4:0]  count;
		logic        empty;
	} list_result_t;

	// Local copy of the list contents
	logic [31:0]  words [CAPACITY];
	int           word_count = 0;
	list_result_t results_due[$];
	list_result_t oldest;
	int           fail_count = 0;
	int           due_count = 0;

	assign mismatches  = fail_count;
	assign outstanding = due_count;

	// Apply one request to the local list and return the answer it gives
	function automatic list_result_t apply_request(input logic [1:0] cmd,
			input logic [4:0] pos, input logic [31:0] val);
		list_result_t r;
		int           hit;
		r.status = ST_OK;
		r.value  = '0;
		hit      = -1;
		case (cmd)
			CMD_INSERT: begin
				// past-count check comes before the full check
				if (pos > word_count)
					r.status = ST_RANGE;
				else if (word_count >= CAPACITY)
					r.status = ST_FULL;
				else begin
					for (int i = word_count; i > pos; i--)
						words[i] = words[i - 1];
					words[pos] = val;
					word_count++;
				end
			end
			CMD_REMOVE, CMD_READ: begin
				if (pos >= word_count)
					r.status = ST_RANGE;
				else begin
					r.value = words[pos];
					if (cmd == CMD_REMOVE)
						hit = pos;
				end
			end
			default: begin
				// remove first match: lowest position wins
				r.status = ST_NOTFOUND;
				for (int i = 0; i < word_count; i++)
					if (hit < 0 && words[i] == val)
						hit = i;
				if (hit >= 0) begin
					r.status = ST_OK;
					r.value  = words[hit];
				end
			end
		endcase
		// close the gap left by a removal
		if (hit >= 0) begin
			for (int i = hit; i + 1 < word_count; i++)
				words[i] = words[i + 1];
			word_count--;
		end
		r.count = 5'(word_count);
		r.empty = (word_count == 0);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t ERROR %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// Results first: a done strobe always answers an earlier request
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (results_due.size() == 0) begin
					fail_count++;
					$display({"%0t ERROR result with none expected: expected nothing",
						" actual status %0d value %0h count %0d"},
						$time, status, value_out, count_out);
				end else begin
					oldest = results_due.pop_front();
					check_field("status", 32'(oldest.status), 32'(status));
					check_field("value_out", oldest.value, value_out);
					check_field("count_out", 32'(oldest.count), 32'(count_out));
					check_field("is_empty", 32'(oldest.empty), 32'(is_empty));
				end
			end
			if (start && !busy)
				results_due.push_back(apply_request(command, position, item_value));
			due_count = results_due.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for the indexed ordered list
// Drives a directed run over the empty, full and out-of-range corners, then
// random command streams that swing between filling and draining the list,
// with sender gaps of varying density. The checker scores every result.
// ----------------------------------------------------------------------------
module tb import iol_pkg::*; ;

	localparam int CAPACITY    = 16;
	localparam int PHASE_ITEMS = 625;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [4:0]  position;
	logic [31:0] item_value;
	logic        done;
	logic [1:0]  status;
	logic [31:0] value_out;
	logic [4:0]  count_out;
	logic        is_empty;
	int          mismatches;
	int          outstanding;
	int          idle_pct;

	// Small value set so remove-first-match finds hits and duplicates
	logic [31:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
		32'h0000_0001, 32'h5555_AAAA, 32'hAAAA_5555, 32'h0000_0007, 32'h7FFF_FFFF};

	indexed_ordered_list #(
		.CAPACITY(CAPACITY),
		.DATA_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.position(position),
		.item_value(item_value),
		.done(done),
		.status(status),
		.value_out(value_out),
		.count_out(count_out),
		.is_empty(is_empty)
	);

	list_checker #(
		.CAPACITY(CAPACITY)
	) u_list_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.position(position),
		.item_value(item_value),
		.done(done),
		.status(status),
		.value_out(value_out),
		.count_out(count_out),
		.is_empty(is_empty),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input logic [1:0] c, input logic [4:0] p,
			input logic [31:0] v);
		logic taken;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		command    <= c;
		position   <= p;
		item_value <= v;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		@(negedge clk);
	endtask

	// Random request, biased toward filling or draining
	task automatic send_random(input logic filling);
		logic [1:0]  c;
		logic [4:0]  p;
		logic [31:0] v;
		int          roll;
		int          hint;
		hint = int'(count_out);
		roll = $urandom_range(0, 99);
		if (filling)
			c = (roll < 55) ? CMD_INSERT : (roll < 70) ? CMD_REMOVE :
				(roll < 85) ? CMD_REMOVE_MATCH : CMD_READ;
		else
			c = (roll < 20) ? CMD_INSERT : (roll < 50) ? CMD_REMOVE :
				(roll < 75) ? CMD_REMOVE_MATCH : CMD_READ;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			p = 5'($urandom_range(0, 31));
		else if (roll == 1)
			p = 5'(hint);
		else if (c == CMD_INSERT || hint == 0)
			p = 5'($urandom_range(0, hint));
		else
			p = 5'($urandom_range(0, hint - 1));
		if ($urandom_range(0, 3) == 0)
			v = $urandom;
		else
			v = value_pool[3'($urandom_range(0, 7))];
		send_request(c, p, v);
	endtask

	initial begin
		logic [4:0]  p;
		logic [31:0] v;
		arst_n     = 1'b0;
		start      = 1'b0;
		command    = CMD_INSERT;
		position   = '0;
		item_value = '0;
		idle_pct   = 25;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Empty list: every access misses
		send_request(CMD_READ, 5'd0, 32'h0);
		send_request(CMD_REMOVE, 5'd0, 32'h0);
		send_request(CMD_REMOVE_MATCH, 5'd0, 32'h0000_1234);
		send_request(CMD_INSERT, 5'd1, 32'h0000_1111);

		// Fill to capacity with prepends, appends and middle inserts
		for (int i = 0; i < CAPACITY; i++) begin
			p = (i % 3 == 0) ? 5'd0 : (i % 3 == 1) ? 5'(i) : 5'(i / 2);
			case (i)
				0:       v = 32'h0000_0000;
				1:       v = 32'hFFFF_FFFF;
				2:       v = 32'h8000_0000;
				5, 9:    v = 32'h5555_AAAA;
				default: v = 32'hA5A5_0000 + 32'(i);
			endcase
			send_request(CMD_INSERT, p, v);
		end

		// Full list: append is refused, past-count wins over full
		send_request(CMD_INSERT, 5'd16, 32'h0000_2222);
		send_request(CMD_INSERT, 5'd17, 32'h0000_3333);
		send_request(CMD_READ, 5'd15, 32'h0);
		send_request(CMD_READ, 5'd31, 32'h0);
		// duplicate value: the lower position goes first
		send_request(CMD_REMOVE_MATCH, 5'd0, 32'h5555_AAAA);
		send_request(CMD_REMOVE, 5'd0, 32'h0);
		send_request(CMD_REMOVE, 5'd13, 32'h0);

		// Random phases: sparse sender gaps, dense gaps, then back to back
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 25 : (ph == 1) ? 62 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random(((n / 48) % 2) == 0);
		end
		start <= 1'b0;

		// Drain
		wait (outstanding == 0);
		repeat (CAPACITY + 4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
rtl/iol_pkg.sv
rtl/iol_cell.sv
rtl/indexed_ordered_list.sv
tb/list_checker.sv
tb/tb.sv
